>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RMBO_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("assertion failed: label");
`define RMBO_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("assertion failed: label");
`else
`define RMBO_ASSERT(label, clk, rst, prop)
`define RMBO_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/rmbo_pkg.sv
package rmbo_pkg;

   localparam int MAX_WALLS = 64;
   localparam int WALL_AW   = $clog2(MAX_WALLS);
   localparam int CNT_W     = $clog2(MAX_WALLS + 1);
   localparam int FRAC      = 14;
   localparam int POS_W     = 32;
   localparam int COORD_W   = 11;
   localparam int ENTRY_W   = 2 * COORD_W;

   // Command codes.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_MOVE  = 2'd2;
   localparam logic [1:0] CMD_CAST  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_WALL_SIZE   = 3'd0;
   localparam logic [2:0] REG_LAMP_RADIUS = 3'd1;
   localparam logic [2:0] REG_SCREEN_W    = 3'd2;
   localparam logic [2:0] REG_SCREEN_H    = 3'd3;
   localparam logic [2:0] REG_MAX_RAY     = 3'd4;

   // Per-wall test results handed from the compare stage to the sequencer.
   typedef struct packed {
      logic ray_in;
      logic lamp_touch;
   } wall_hit_type;

   // Saturate a floored pixel value to 14 signed bits.
   function automatic logic signed [13:0] sat14(input logic signed [17:0] v);
      logic signed [13:0] r;
      if (v > 18'sd8191) begin
         r = 14'sd8191;
      end else if (v < -18'sd8192) begin
         r = -14'sd8192;
      end else begin
         r = v[13:0];
      end
      return r;
   endfunction

   // Saturate a floored pixel value to 13 signed bits.
   function automatic logic signed [12:0] sat13(input logic signed [17:0] v);
      logic signed [12:0] r;
      if (v > 18'sd4095) begin
         r = 13'sd4095;
      end else if (v < -18'sd4096) begin
         r = -13'sd4096;
      end else begin
         r = v[12:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/rmbo_wall_ram.sv
module rmbo_wall_ram
   import rmbo_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [WALL_AW-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0]   wr_data,
   input  logic [WALL_AW-1:0]   rd_addr,
   output logic [ENTRY_W-1:0]   rd_data
);

   logic [ENTRY_W-1:0] mem [MAX_WALLS];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Single write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rmbo_wall_cmp.sv
module rmbo_wall_cmp
   import rmbo_pkg::*;
(
   input  logic                     clock,
   input  logic                     mul_en,
   input  logic [ENTRY_W-1:0]       rd_data,
   input  logic [7:0]               wall_size,
   input  logic [7:0]               radius,
   input  logic signed [POS_W-1:0]  px,
   input  logic signed [POS_W-1:0]  py,
   input  logic [COORD_W-1:0]       lx,
   input  logic [COORD_W-1:0]       ly,
   output wall_hit_type             hit
);

   logic [18:0] wx_ff, wy_ff;
   logic [19:0] wxe, wye;
   logic signed [35:0] px_e, py_e;
   logic signed [35:0] wx_q, wy_q, wxe_q, wye_q;
   logic [20:0] lx_lo, lx_hi, ly_lo, ly_hi;

   // Wall corner in pixels, one multiply per axis.
   always_ff @(posedge clock) begin
      if (mul_en) begin
         wx_ff <= rd_data[COORD_W-1:0] * wall_size;
         wy_ff <= rd_data[ENTRY_W-1:COORD_W] * wall_size;
      end
   end

   assign wxe = 20'(wx_ff) + 20'(wall_size);
   assign wye = 20'(wy_ff) + 20'(wall_size);

   // Ray point inside the wall, bounds inclusive, in Q14.
   assign px_e  = {{4{px[POS_W-1]}}, px};
   assign py_e  = {{4{py[POS_W-1]}}, py};
   assign wx_q  = $signed({3'b000, wx_ff, 14'd0});
   assign wy_q  = $signed({3'b000, wy_ff, 14'd0});
   assign wxe_q = $signed({2'b00, wxe, 14'd0});
   assign wye_q = $signed({2'b00, wye, 14'd0});
   assign hit.ray_in = (px_e >= wx_q) && (px_e <= wxe_q) &&
                       (py_e >= wy_q) && (py_e <= wye_q);

   // Lamp square touches the wall: x - r <= wx + ws and x + r >= wx.
   assign lx_lo = 21'(lx);
   assign ly_lo = 21'(ly);
   assign lx_hi = 21'(lx) + 21'(radius);
   assign ly_hi = 21'(ly) + 21'(radius);
   assign hit.lamp_touch = (lx_lo <= 21'(wxe) + 21'(radius)) && (lx_hi >= 21'(wx_ff)) &&
                           (ly_lo <= 21'(wye) + 21'(radius)) && (ly_hi >= 21'(wy_ff));

endmodule

>>> rtl/ray_march_box_occlusion.sv
// Add wall and clear go straight to the result word; a move lamp in bounds
// reads, multiplies and compares each wall in turn; a cast ray does the same
// for every wall at each step of the march, held to the one wall memory read
// port and the per-wall multiply and compare.
// One word is worked on at a time. Reset is synchronous and active high; it
// restores the register defaults, empties the wall table and puts the lamp at 400, 300.
module ray_march_box_occlusion
   import rmbo_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [10:0]         req_cell_col,
   input  logic [10:0]         req_cell_row,
   input  logic [10:0]         req_pos_x,
   input  logic [10:0]         req_pos_y,
   input  logic signed [15:0]  req_dir_cos,
   input  logic signed [15:0]  req_dir_sin,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic                rsp_hit,
   output logic signed [12:0]  rsp_start_x,
   output logic signed [12:0]  rsp_start_y,
   output logic signed [13:0]  rsp_end_x,
   output logic signed [13:0]  rsp_end_y,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [11:0]         csr_wdata
);

`include "assert_macros.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_STEP = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   logic [7:0]  wall_size_ff, lamp_radius_ff;
   logic [10:0] screen_w_ff, screen_h_ff;
   logic [11:0] max_ray_ff;

   logic [CNT_W-1:0]  wall_count_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [10:0]       lamp_x_ff, lamp_y_ff;
   logic [1:0]        cmd_ff;
   logic [10:0]       mv_x_ff, mv_y_ff;
   logic signed [15:0] c_ff, s_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, prev_x_ff, prev_y_ff;
   logic [11:0]       step_ff;

   logic [1:0]         res_status_ff;
   logic               res_hit_ff;
   logic signed [12:0] res_sx_ff, res_sy_ff;
   logic signed [13:0] res_ex_ff, res_ey_ff;
   logic               rsp_valid_ff;

   logic               accept, out_load, mul_en, ram_we;
   logic [ENTRY_W-1:0] rd_data;
   wall_hit_type       wall_hit;
   logic               in_bounds;
   logic signed [POS_W-1:0] ox, oy, cx, sy_ext;
   logic signed [24:0] cr, sr;
   logic signed [POS_W-1:0] start_x_sum, start_y_sum;
   logic               cur_hit;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign mul_en    = (state_ff == S_MUL);
   assign ram_we    = accept && (req_cmd == CMD_ADD) && (wall_count_ff != CNT_W'(MAX_WALLS));

   rmbo_wall_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wall_count_ff[WALL_AW-1:0]),
      .wr_data ({req_cell_row, req_cell_col}),
      .rd_addr (idx_ff[WALL_AW-1:0]),
      .rd_data (rd_data)
   );

   rmbo_wall_cmp u_cmp (
      .clock     (clock),
      .mul_en    (mul_en),
      .rd_data   (rd_data),
      .wall_size (wall_size_ff),
      .radius    (lamp_radius_ff),
      .px        (px_ff),
      .py        (py_ff),
      .lx        (mv_x_ff),
      .ly        (mv_y_ff),
      .hit       (wall_hit)
   );

   // Ray origin, first point and start point in Q14.
   assign ox = $signed({7'd0, lamp_x_ff, 14'd0});
   assign oy = $signed({7'd0, lamp_y_ff, 14'd0});
   assign cx = {{16{req_dir_cos[15]}}, req_dir_cos};
   assign sy_ext = {{16{req_dir_sin[15]}}, req_dir_sin};
   assign cr = req_dir_cos * $signed({1'b0, lamp_radius_ff});
   assign sr = req_dir_sin * $signed({1'b0, lamp_radius_ff});
   assign start_x_sum = ox + {{7{cr[24]}}, cr};
   assign start_y_sum = oy - {{7{sr[24]}}, sr};

   assign in_bounds = (req_pos_x != 11'd0) && (req_pos_x < screen_w_ff) &&
                      (req_pos_y != 11'd0) && (req_pos_y < screen_h_ff);
   assign cur_hit = (cmd_ff == CMD_CAST) ? wall_hit.ray_in : wall_hit.lamp_touch;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_MOVE: state_in = (in_bounds && wall_count_ff != '0) ? S_RD : S_OUT;
                  CMD_CAST: begin
                     if (max_ray_ff < 12'd2) begin
                        state_in = S_OUT;
                     end else begin
                        state_in = (wall_count_ff != '0) ? S_RD : S_STEP;
                     end
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_RD:  state_in = S_MUL;
         S_MUL: state_in = S_CMP;
         S_CMP: begin
            if (cur_hit) begin
               state_in = S_OUT;
            end else if (idx_ff + 1'b1 == wall_count_ff) begin
               state_in = (cmd_ff == CMD_CAST) ? S_STEP : S_OUT;
            end else begin
               state_in = S_RD;
            end
         end
         S_STEP: begin
            if (13'(step_ff) + 13'd1 >= 13'(max_ray_ff)) begin
               state_in = S_OUT;
            end else begin
               state_in = (wall_count_ff != '0) ? S_RD : S_STEP;
            end
         end
         S_OUT: state_in = out_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // Control state, configuration and lamp.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wall_size_ff   <= 8'd50;
         lamp_radius_ff <= 8'd15;
         screen_w_ff    <= 11'd800;
         screen_h_ff    <= 11'd600;
         max_ray_ff     <= 12'd1000;
         wall_count_ff  <= '0;
         lamp_x_ff      <= 11'd400;
         lamp_y_ff      <= 11'd300;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_WALL_SIZE:   wall_size_ff   <= csr_wdata[7:0];
               REG_LAMP_RADIUS: lamp_radius_ff <= csr_wdata[7:0];
               REG_SCREEN_W:    screen_w_ff    <= csr_wdata[10:0];
               REG_SCREEN_H:    screen_h_ff    <= csr_wdata[10:0];
               REG_MAX_RAY:     max_ray_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (ram_we) begin
            wall_count_ff <= wall_count_ff + 1'b1;
         end else if (accept && req_cmd == CMD_CLEAR) begin
            wall_count_ff <= '0;
         end
         // A move is taken when the bounds hold and no wall is touched.
         if (accept && req_cmd == CMD_MOVE && in_bounds && wall_count_ff == '0) begin
            lamp_x_ff <= req_pos_x;
            lamp_y_ff <= req_pos_y;
         end else if (state_ff == S_CMP && cmd_ff == CMD_MOVE && !cur_hit &&
                      idx_ff + 1'b1 == wall_count_ff) begin
            lamp_x_ff <= mv_x_ff;
            lamp_y_ff <= mv_y_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: march position, wall index and pending result.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_cmd;
         mv_x_ff       <= req_pos_x;
         mv_y_ff       <= req_pos_y;
         c_ff          <= req_dir_cos;
         s_ff          <= req_dir_sin;
         idx_ff        <= '0;
         step_ff       <= 12'd1;
         px_ff         <= ox + cx;
         py_ff         <= oy - sy_ext;
         prev_x_ff     <= ox;
         prev_y_ff     <= oy;
         res_status_ff <= ST_DONE;
         res_hit_ff    <= 1'b0;
         res_sx_ff     <= '0;
         res_sy_ff     <= '0;
         res_ex_ff     <= '0;
         res_ey_ff     <= '0;
         case (req_cmd)
            CMD_ADD: begin
               if (wall_count_ff == CNT_W'(MAX_WALLS)) begin
                  res_status_ff <= ST_FULL;
               end
            end
            CMD_MOVE: begin
               if (!in_bounds) begin
                  res_status_ff <= ST_REFUSED;
               end
            end
            CMD_CAST: begin
               res_sx_ff <= sat13(start_x_sum[POS_W-1:FRAC]);
               res_sy_ff <= sat13(start_y_sum[POS_W-1:FRAC]);
               res_ex_ff <= sat14(ox[POS_W-1:FRAC]);
               res_ey_ff <= sat14(oy[POS_W-1:FRAC]);
            end
            default: ;
         endcase
      end else if (state_ff == S_CMP) begin
         if (cur_hit) begin
            if (cmd_ff == CMD_CAST) begin
               res_hit_ff <= 1'b1;
               res_ex_ff  <= sat14(prev_x_ff[POS_W-1:FRAC]);
               res_ey_ff  <= sat14(prev_y_ff[POS_W-1:FRAC]);
            end else begin
               res_status_ff <= ST_REFUSED;
            end
         end else if (idx_ff + 1'b1 == wall_count_ff) begin
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end else if (state_ff == S_STEP) begin
         // No wall at this step: it becomes the last clear point.
         prev_x_ff <= px_ff;
         prev_y_ff <= py_ff;
         px_ff     <= px_ff + {{16{c_ff[15]}}, c_ff};
         py_ff     <= py_ff - {{16{s_ff[15]}}, s_ff};
         step_ff   <= step_ff + 1'b1;
         res_ex_ff <= sat14(px_ff[POS_W-1:FRAC]);
         res_ey_ff <= sat14(py_ff[POS_W-1:FRAC]);
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status  <= res_status_ff;
         rsp_hit     <= res_hit_ff;
         rsp_start_x <= res_sx_ff;
         rsp_start_y <= res_sy_ff;
         rsp_end_x   <= res_ex_ff;
         rsp_end_y   <= res_ey_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RMBO_ASSERT(a_count_range, clock, reset, wall_count_ff <= CNT_W'(MAX_WALLS))
   `RMBO_ASSERT(a_hit_done, clock, reset, (rsp_valid && rsp_hit) |-> (rsp_status == ST_DONE))
   `RMBO_ASSERT(a_busy_after_accept, clock, reset, accept |=> (state_ff != S_IDLE))
   `RMBO_ASSERT(a_scan_in_range, clock, reset, (state_ff == S_CMP) |-> (idx_ff < wall_count_ff))

endmodule

>>> verif/tb_ray_march_box_occlusion.sv
module tb_ray_march_box_occlusion;
   import rmbo_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]         cmd;
      logic [10:0]        col;
      logic [10:0]        row;
      logic [10:0]        px;
      logic [10:0]        py;
      logic signed [15:0] dcos;
      logic signed [15:0] dsin;
   } cmd_word_type;

   typedef struct {
      logic [1:0]         status;
      logic               hit;
      logic signed [12:0] sx;
      logic signed [12:0] sy;
      logic signed [13:0] ex;
      logic signed [13:0] ey;
   } ray_word_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic [10:0]        req_cell_col;
   logic [10:0]        req_cell_row;
   logic [10:0]        req_pos_x;
   logic [10:0]        req_pos_y;
   logic signed [15:0] req_dir_cos;
   logic signed [15:0] req_dir_sin;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic               rsp_hit;
   logic signed [12:0] rsp_start_x;
   logic signed [12:0] rsp_start_y;
   logic signed [13:0] rsp_end_x;
   logic signed [13:0] rsp_end_y;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [11:0]        csr_wdata;

   ray_march_box_occlusion dut (.*);

   // Mirror of the block's registers and state.
   int unsigned m_ws, m_lr, m_sw, m_sh, m_mr;
   int unsigned m_cnt, m_lx, m_ly;
   int unsigned m_col [MAX_WALLS];
   int unsigned m_row [MAX_WALLS];

   cmd_word_type pending_cmds[$];
   ray_word_type expected_rays[$];
   cmd_word_type cur_cmd;
   int        send_idle;
   int        recv_idle;
   int        n_accepted;
   int        hold_cnt;
   bit        hold_done;
   int        n_errors;
   int        gen_walls;

   // Clock.
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint clip(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // A Q14 point lies in a wall when it is inside or on the wall's border.
   function automatic bit point_blocked(longint qx, longint qy);
      longint wx, wy, ws;
      ws = m_ws;
      for (int i = 0; i < m_cnt; i++) begin
         wx = longint'(m_col[i]) * ws;
         wy = longint'(m_row[i]) * ws;
         if (qx >= (wx <<< FRAC) && qx <= ((wx + ws) <<< FRAC) &&
             qy >= (wy <<< FRAC) && qy <= ((wy + ws) <<< FRAC)) return 1;
      end
      return 0;
   endfunction

   function automatic bit lamp_blocked(longint x, longint y);
      longint wx, wy, r, ws;
      r = m_lr;
      ws = m_ws;
      for (int i = 0; i < m_cnt; i++) begin
         wx = longint'(m_col[i]) * ws;
         wy = longint'(m_row[i]) * ws;
         if (x - r <= wx + ws && x + r >= wx && y - r <= wy + ws && y + r >= wy)
            return 1;
      end
      return 0;
   endfunction

   // Apply one command word to the mirror and work out the answer word.
   function automatic ray_word_type march_ray(cmd_word_type w);
      ray_word_type r;
      longint c, s, ox, oy, last, lr;
      r = '{status: ST_DONE, hit: 0, sx: 0, sy: 0, ex: 0, ey: 0};
      case (w.cmd)
         CMD_ADD: begin
            if (m_cnt >= MAX_WALLS) begin
               r.status = ST_FULL;
            end else begin
               m_col[m_cnt] = w.col;
               m_row[m_cnt] = w.row;
               m_cnt++;
            end
         end
         CMD_CLEAR: begin
            m_cnt = 0;
         end
         CMD_MOVE: begin
            if (w.px > 0 && w.px < m_sw && w.py > 0 && w.py < m_sh &&
                !lamp_blocked(w.px, w.py)) begin
               m_lx = w.px;
               m_ly = w.py;
            end else begin
               r.status = ST_REFUSED;
            end
         end
         default: begin
            c = w.dcos;
            s = w.dsin;
            lr = m_lr;
            ox = longint'(m_lx) <<< FRAC;
            oy = longint'(m_ly) <<< FRAC;
            last = 0;
            for (longint k = 1; k < m_mr; k++) begin
               if (point_blocked(ox + c * k, oy - s * k)) begin
                  r.hit = 1;
                  last = k - 1;
                  break;
               end
               last = k;
            end
            r.sx = 13'(clip((ox + c * lr) >>> FRAC, 13));
            r.sy = 13'(clip((oy - s * lr) >>> FRAC, 13));
            r.ex = 14'(clip((ox + c * last) >>> FRAC, 14));
            r.ey = 14'(clip((oy - s * last) >>> FRAC, 14));
         end
      endcase
      return r;
   endfunction

   // Driver: offers queued command words and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         n_accepted <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_rays.insert(expected_rays.size(), march_ray(cur_cmd));
            n_accepted <= n_accepted + 1;
         end
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
            cur_cmd = pending_cmds.pop_front();
            req_valid <= 1;
            req_cmd <= cur_cmd.cmd;
            req_cell_col <= cur_cmd.col;
            req_cell_row <= cur_cmd.row;
            req_pos_x <= cur_cmd.px;
            req_pos_y <= cur_cmd.py;
            req_dir_cos <= cur_cmd.dcos;
            req_dir_sin <= cur_cmd.dsin;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // One long receiver hold-off so the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_done <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (!hold_done && n_accepted == 150) begin
         hold_cnt <= 500;
         hold_done <= 1;
      end
   end

   // Monitor: compares each answer word with the oldest expectation.
   always @(posedge clock) begin
      ray_word_type e;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rays.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) $display("Unexpected answer word, status %0d", rsp_status);
            end else begin
               e = expected_rays.pop_front();
               if (rsp_status !== e.status || rsp_hit !== e.hit ||
                   rsp_start_x !== e.sx || rsp_start_y !== e.sy ||
                   rsp_end_x !== e.ex || rsp_end_y !== e.ey) begin
                  n_errors++;
                  if (n_errors <= 10)
                     $display({"Mismatch: expected st %0d hit %0d s %0d,%0d e %0d,%0d;",
                               " got st %0d hit %0d s %0d,%0d e %0d,%0d"},
                        e.status, e.hit, e.sx, e.sy, e.ex, e.ey, rsp_status, rsp_hit,
                        rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y);
               end
            end
         end
         rsp_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= 12'(val);
      case (idx)
         REG_WALL_SIZE:   m_ws = val & 8'hff;
         REG_LAMP_RADIUS: m_lr = val & 8'hff;
         REG_SCREEN_W:    m_sw = val & 11'h7ff;
         REG_SCREEN_H:    m_sh = val & 11'h7ff;
         default:         m_mr = val & 12'hfff;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_regs(int unsigned ws, int unsigned lr, int unsigned sw,
                           int unsigned sh, int unsigned mr);
      write_reg(REG_WALL_SIZE, ws);
      write_reg(REG_LAMP_RADIUS, lr);
      write_reg(REG_SCREEN_W, sw);
      write_reg(REG_SCREEN_H, sh);
      write_reg(REG_MAX_RAY, mr);
   endtask

   // Queue a word; fields that the command ignores carry random bits.
   task automatic push_cmd(logic [1:0] cmd, int col, int row, int px, int py,
                           int dc, int ds);
      cmd_word_type w;
      w.cmd = cmd;
      w.col = (col < 0) ? 11'($urandom) : 11'(col);
      w.row = (row < 0) ? 11'($urandom) : 11'(row);
      w.px = (px < 0) ? 11'($urandom) : 11'(px);
      w.py = (py < 0) ? 11'($urandom) : 11'(py);
      w.dcos = (dc == 99999) ? 16'($urandom) : 16'(dc);
      w.dsin = (ds == 99999) ? 16'($urandom) : 16'(ds);
      if (cmd == CMD_ADD && gen_walls < MAX_WALLS) gen_walls++;
      if (cmd == CMD_CLEAR) gen_walls = 0;
      pending_cmds.insert(pending_cmds.size(), w);
   endtask

   // Wait until every word is accepted and answered.
   task automatic drain();
      while (pending_cmds.size() != 0 || req_valid || expected_rays.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random words: walls near the lamp, so most rays stop at one.
   task automatic push_random(int n);
      int r, d;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 5 || (gen_walls > 12 && r < 40)) begin
            push_cmd(CMD_CLEAR, -1, -1, -1, -1, 99999, 99999);
         end else if (r < 40) begin
            if ($urandom_range(9) < 8)
               push_cmd(CMD_ADD, $urandom_range(25), $urandom_range(25), -1, -1, 99999, 99999);
            else
               push_cmd(CMD_ADD, -1, -1, -1, -1, 99999, 99999);
         end else if (r < 65) begin
            if ($urandom_range(9) < 8)
               push_cmd(CMD_MOVE, -1, -1, $urandom_range(1000), $urandom_range(1000),
                        99999, 99999);
            else
               push_cmd(CMD_MOVE, -1, -1, -1, -1, 99999, 99999);
         end else begin
            d = ($urandom_range(9) == 0) ? 99999 : 0;
            if (d == 0)
               push_cmd(CMD_CAST, -1, -1, -1, -1, $urandom_range(32768) - 16384,
                        $urandom_range(32768) - 16384);
            else
               push_cmd(CMD_CAST, -1, -1, -1, -1, 99999, 99999);
         end
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = 0;
      req_cell_col = 0;
      req_cell_row = 0;
      req_pos_x = 0;
      req_pos_y = 0;
      req_dir_cos = 0;
      req_dir_sin = 0;
      rsp_ready = 0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      n_errors = 0;
      gen_walls = 0;
      send_idle = 22;
      recv_idle = 62;
      m_ws = 50; m_lr = 15; m_sw = 800; m_sh = 600; m_mr = 1000;
      m_cnt = 0; m_lx = 400; m_ly = 300;
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed words with the reset register values.
      push_cmd(CMD_CAST, -1, -1, -1, -1, 16384, 0);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 0, -16384);
      push_cmd(CMD_CAST, -1, -1, -1, -1, -32768, 32767);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 32767, -32768);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 0, 0);
      push_cmd(CMD_MOVE, -1, -1, 0, 0, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 2047, 2047, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 800, 300, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 799, 599, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 400, 300, 99999, 99999);
      push_cmd(CMD_ADD, 9, 6, -1, -1, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 16384, 0);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 11585, -11585);
      push_cmd(CMD_MOVE, -1, -1, 430, 300, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 436, 300, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 400, 300, 99999, 99999);
      push_cmd(CMD_ADD, 2047, 2047, -1, -1, 99999, 99999);
      push_cmd(CMD_ADD, 0, 0, -1, -1, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, -16384, 16384);
      push_cmd(CMD_CLEAR, -1, -1, -1, -1, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, -16384, -16384);
      drain();

      // Largest walls and radius, single-step rays; fill the table past full.
      set_regs(255, 255, 2047, 1, 2);
      for (int i = 0; i < MAX_WALLS + 2; i++)
         push_cmd(CMD_ADD, -1, -1, -1, -1, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 5, 0, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 16384, 16384);
      push_cmd(CMD_CLEAR, -1, -1, -1, -1, 99999, 99999);
      push_cmd(CMD_MOVE, -1, -1, 1000, 1, 99999, 99999);
      drain();

      // Smallest walls and radius, the longest ray.
      set_regs(1, 0, 1, 2047, 4095);
      push_cmd(CMD_MOVE, -1, -1, 1000, 1, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, -16384, 0);
      push_cmd(CMD_ADD, 1000, 3000 % 2048, -1, -1, 99999, 99999);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 0, -16384);
      push_cmd(CMD_CAST, -1, -1, -1, -1, 16384, 16384);
      push_cmd(CMD_CLEAR, -1, -1, -1, -1, 99999, 99999);
      drain();

      // Random phases under changing registers and idling.
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            send_idle <= 62;
            recv_idle <= 22;
         end else if (ph == 4) begin
            send_idle <= 0;
            recv_idle <= 0;
         end
         set_regs($urandom_range(8, 80), $urandom_range(0, 40), $urandom_range(300, 2047),
                  $urandom_range(300, 2047), $urandom_range(2, 40));
         push_random(84);
         drain();
      end

      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
